[hdl/pdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants of the point deduplication block.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

	// coordinate and distance arithmetic
	localparam int COORD_BITS  = 24;
	localparam int POINT_BITS  = 3 * COORD_BITS;
	localparam int SLOT_BITS   = 8;
	localparam int THRESH_BITS = 52;
	localparam int FAR_BITS    = 26;
	localparam int MAG_W       = 33;
	localparam int SQ_BITS     = 2 * FAR_BITS;
	localparam int SUM_BITS    = SQ_BITS + 2;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(655);

	// configuration port
	localparam int PADDR_BITS = 4;
	localparam int PDATA_BITS = 64;
	localparam logic REG_THRESH = 1'b0;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   kind;
		coord_t first_x;
		coord_t first_y;
		coord_t first_z;
		coord_t second_x;
		coord_t second_y;
		coord_t second_z;
	} item_t;

	typedef struct packed {
		coord_t                point_x;
		coord_t                point_y;
		coord_t                point_z;
		logic [SLOT_BITS-1:0]  slot;
		logic                  dropped;
		logic                  last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic clear;
		logic read;
		logic emit1;
		logic emit2;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic pipe_idle;
		logic add1;
		logic add2;
	} sts_t;

endpackage

[hdl/pdd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/pdd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_ctrl
// Sequencer: accepts an item, runs the table scan, drains, emits results.
// ----------------------------------------------------------------------------
module pdd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          kind,
	input  pdd_pkg::sts_t sts,
	output pdd_pkg::cmd_t cmd,
	output logic          busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_EMIT1 = 3'd3;
	localparam logic [2:0] S_EMIT2 = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (kind) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_d = S_DRAIN;
				end else begin
					cmd.read = 1'b1;
				end
			end
			S_DRAIN: begin
				if (sts.pipe_idle) begin
					state_d = S_EMIT1;
				end
			end
			S_EMIT1: begin
				cmd.emit1 = sts.add1;
				state_d   = S_EMIT2;
			end
			S_EMIT2: begin
				cmd.emit2 = sts.add2;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef SYNTH
	// results go out only after the scan is complete and the pipe is empty
	a_emit_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT1) |-> (sts.pipe_idle && sts.scan_done))
		else $error("emit started with scan still in flight");

	// an accepted edge always starts a scan
	a_edge_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && !kind) |=> (state_q == S_SCAN))
		else $error("edge accepted without scan");

	// second endpoint follows the first one
	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT2) |-> ($past(state_q) == S_EMIT1))
		else $error("second endpoint emitted out of order");
`endif

endmodule

[hdl/pdd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdd_dp
// Datapath: point table, scan counter, distance pipeline, count and results.
// ----------------------------------------------------------------------------
module pdd_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pdd_pkg::item_t                   item,
	input  logic [pdd_pkg::THRESH_BITS-1:0]  thr,
	input  pdd_pkg::cmd_t                    cmd,
	output pdd_pkg::sts_t                    sts,
	output pdd_pkg::result_t                 result,
	output logic                             result_valid
);

	localparam logic [pdd_pkg::MAG_W-1:0] FAR_LIMIT =
		pdd_pkg::MAG_W'(1) << pdd_pkg::FAR_BITS;

	// held endpoints of the current edge
	pdd_pkg::coord_t pt_q [2][3];

	logic                            known_q [2];
	logic [pdd_pkg::COUNT_BITS-1:0]  idx_q;
	logic [pdd_pkg::COUNT_BITS-1:0]  cnt_q;
	logic                            rv_s0;
	logic                            v_s1;
	logic                            v_s2;
	logic [pdd_pkg::FAR_BITS-1:0]    mag_s1 [2][3];
	logic                            far_s1 [2][3];
	logic [pdd_pkg::SQ_BITS-1:0]     sq_s2 [2][3];
	logic                            far_s2 [2];

	logic [pdd_pkg::POINT_BITS-1:0]  rdata;
	logic [pdd_pkg::POINT_BITS-1:0]  wdata;
	logic                            we;
	logic                            full;
	logic [pdd_pkg::MAG_W-1:0]       mag_c [2][3];
	logic                            near_c [2];
	logic                            emit;
	logic                            sel2;

	assign full = (cnt_q >= pdd_pkg::COUNT_BITS'(pdd_pkg::TABLE_DEPTH));
	assign emit = cmd.emit1 | cmd.emit2;
	assign sel2 = cmd.emit2;
	assign we   = emit & ~full;

	// new point goes into the table as {z, y, x}
	always_comb begin
		if (sel2) begin
			wdata = {pt_q[1][2], pt_q[1][1], pt_q[1][0]};
		end else begin
			wdata = {pt_q[0][2], pt_q[0][1], pt_q[0][0]};
		end
	end

	pdd_ram #(
		.WIDTH(pdd_pkg::POINT_BITS),
		.DEPTH(pdd_pkg::TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[pdd_pkg::ADDR_BITS-1:0]),
		.wdata(wdata),
		.re   (cmd.read),
		.raddr(idx_q[pdd_pkg::ADDR_BITS-1:0]),
		.rdata(rdata)
	);

	// coordinate differences and magnitudes against the entry read
	always_comb begin
		logic signed [pdd_pkg::COORD_BITS:0] diff;
		logic [pdd_pkg::COORD_BITS:0]        mag;
		pdd_pkg::coord_t                     ent;
		for (int i = 0; i < 2; i++) begin
			for (int k = 0; k < 3; k++) begin
				ent  = rdata[k*pdd_pkg::COORD_BITS +: pdd_pkg::COORD_BITS];
				diff = {pt_q[i][k][pdd_pkg::COORD_BITS-1], pt_q[i][k]} -
					{ent[pdd_pkg::COORD_BITS-1], ent};
				mag  = diff[pdd_pkg::COORD_BITS] ? -diff : diff;
				mag_c[i][k] = pdd_pkg::MAG_W'(mag);
			end
		end
	end

	// sum of squares against the threshold
	always_comb begin
		logic [pdd_pkg::SUM_BITS-1:0] sum;
		for (int i = 0; i < 2; i++) begin
			sum = pdd_pkg::SUM_BITS'(sq_s2[i][0]) + pdd_pkg::SUM_BITS'(sq_s2[i][1]) +
				pdd_pkg::SUM_BITS'(sq_s2[i][2]);
			near_c[i] = !far_s2[i] && (sum < pdd_pkg::SUM_BITS'(thr));
		end
	end

	// distance pipeline payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			for (int k = 0; k < 3; k++) begin
				mag_s1[i][k] <= mag_c[i][k][pdd_pkg::FAR_BITS-1:0];
				far_s1[i][k] <= (mag_c[i][k] >= FAR_LIMIT);
				sq_s2[i][k]  <= pdd_pkg::SQ_BITS'(mag_s1[i][k]) *
					pdd_pkg::SQ_BITS'(mag_s1[i][k]);
			end
			far_s2[i] <= far_s1[i][0] | far_s1[i][1] | far_s1[i][2];
		end
	end

	// endpoint capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pt_q[0][0] <= item.first_x;
			pt_q[0][1] <= item.first_y;
			pt_q[0][2] <= item.first_z;
			pt_q[1][0] <= item.second_x;
			pt_q[1][1] <= item.second_y;
			pt_q[1][2] <= item.second_z;
		end
	end

	// scan control, known flags, point count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q[0]   <= 1'b0;
			known_q[1]   <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			rv_s0        <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			rv_s0        <= cmd.read;
			v_s1         <= rv_s0;
			v_s2         <= v_s1;
			result_valid <= emit;
			if (cmd.load) begin
				known_q[0] <= 1'b0;
				known_q[1] <= 1'b0;
				idx_q      <= '0;
			end else begin
				if (cmd.read) begin
					idx_q <= idx_q + 1'b1;
				end
				if (v_s2) begin
					known_q[0] <= known_q[0] | near_c[0];
					known_q[1] <= known_q[1] | near_c[1];
				end
			end
			if (cmd.clear) begin
				cnt_q <= '0;
			end else if (we) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// result beat
	always_ff @(posedge clk) begin
		if (emit) begin
			result.point_x <= sel2 ? pt_q[1][0] : pt_q[0][0];
			result.point_y <= sel2 ? pt_q[1][1] : pt_q[0][1];
			result.point_z <= sel2 ? pt_q[1][2] : pt_q[0][2];
			result.slot    <= full ? '0 : pdd_pkg::SLOT_BITS'(cnt_q);
			result.dropped <= full;
			result.last    <= sel2 | known_q[1];
		end
	end

	assign sts.scan_done = (idx_q == cnt_q);
	assign sts.pipe_idle = ~rv_s0 & ~v_s1 & ~v_s2;
	assign sts.add1      = ~known_q[0];
	assign sts.add2      = ~known_q[1];

`ifndef SYNTH
	// a stored point bumps the count by one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("point count did not advance on store");

	// table reads and writes never overlap
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && (cmd.read || !sts.pipe_idle)))
		else $error("table write during scan");

	// the count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pdd_pkg::COUNT_BITS'(pdd_pkg::TABLE_DEPTH))
		else $error("point count beyond table depth");
`endif

endmodule

[hdl/point_dedup_by_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_dedup_by_distance
// Keeps a table of unique 3D points, filtering edge endpoints by distance.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. An edge item
//   (kind 0) carries two endpoints; a clear item (kind 1) empties the table
//   and gives no result.
//   Each endpoint whose squared distance to every point stored before this
//   edge is not below the threshold is a new point: it is sent out as one
//   beat, marked by result_valid for a single cycle, first endpoint first,
//   with its slot, or with dropped set once the table holds 256 points.
//   last marks the final beat of an edge; an edge of two known points gives
//   no beat.
//   Timing: the table scan reads one entry per cycle from a single-read-port
//   RAM, so an edge takes longer the more points are stored; busy stays high
//   until the edge is through, and no new item is taken before then.
//   Results are not held: the receiver takes every beat as it comes.
//   After reset the table is empty and the threshold is 655 (distance 0.1).
//   The threshold is written over the APB port at address 0 while idle.
// ----------------------------------------------------------------------------
module point_dedup_by_distance (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  pdd_pkg::item_t                  item,
	output pdd_pkg::result_t                result,
	output logic                            result_valid,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pdd_pkg::PADDR_BITS-1:0]  paddr,
	input  logic [pdd_pkg::PDATA_BITS-1:0]  pwdata,
	output logic [pdd_pkg::PDATA_BITS-1:0]  prdata,
	output logic                            pready
);

	logic [pdd_pkg::THRESH_BITS-1:0] thr_q;
	logic                            reg_idx;
	logic                            wr_en;
	pdd_pkg::cmd_t                   cmd;
	pdd_pkg::sts_t                   sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[pdd_pkg::PADDR_BITS-1];
	assign wr_en   = psel & penable & pwrite & pready & (reg_idx == pdd_pkg::REG_THRESH);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pdd_pkg::THRESH_RESET;
		end else if (wr_en) begin
			thr_q <= pwdata[pdd_pkg::THRESH_BITS-1:0];
		end
	end

	// register read
	always_comb begin
		prdata = '0;
		if (reg_idx == pdd_pkg::REG_THRESH) begin
			prdata = pdd_pkg::PDATA_BITS'(thr_q);
		end
	end

	pdd_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (item.kind),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy)
	);

	pdd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.thr         (thr_q),
		.cmd         (cmd),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

[verif/tb_point_dedup_by_distance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_dedup_by_distance
// Self-checking bench for the distance-based point deduplication block.
// Edges and clear items go in through the start/busy handshake. A scoreboard
// keeps its own point table and threshold and predicts every new-point beat;
// each beat is checked field by field as it appears. Directed tests cover
// field extremes, the threshold boundary, a full table and the register
// port. Random phases then run under several threshold settings, all but the
// last with random input gaps.
// ----------------------------------------------------------------------------
module tb_point_dedup_by_distance;

	localparam logic KIND_EDGE  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;
	localparam logic [pdd_pkg::PADDR_BITS-1:0] ADDR_THRESH =
		pdd_pkg::PADDR_BITS'(8 * int'(pdd_pkg::REG_THRESH));
	localparam logic [pdd_pkg::PADDR_BITS-1:0] ADDR_UNUSED = pdd_pkg::PADDR_BITS'(8);
	localparam logic [pdd_pkg::THRESH_BITS-1:0] THRESH_MAX = '1;
	localparam int DRAIN_CYCLES = pdd_pkg::TABLE_DEPTH + 16;

	typedef struct packed {
		pdd_pkg::coord_t x;
		pdd_pkg::coord_t y;
		pdd_pkg::coord_t z;
	} pt_t;

	// dut signals
	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	pdd_pkg::item_t                 item;
	pdd_pkg::result_t               result;
	logic                           result_valid;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [pdd_pkg::PADDR_BITS-1:0] paddr;
	logic [pdd_pkg::PDATA_BITS-1:0] pwdata;
	logic [pdd_pkg::PDATA_BITS-1:0] prdata;
	logic                           pready;

	// scoreboard state
	pt_t                             stored_pts [pdd_pkg::TABLE_DEPTH];
	int                              stored_cnt;
	logic [pdd_pkg::THRESH_BITS-1:0] dist_limit;
	pdd_pkg::result_t                pending_points [$];
	pdd_pkg::result_t                chk_want;

	// run statistics
	int mismatches;
	int items_taken;
	int clears_taken;
	int beats_checked;
	int drops_seen;
	int limits_used;

	point_dedup_by_distance u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.result      (result),
		.result_valid(result_valid),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop
	initial begin
		#20_000_000;
		$display("point_dedup_by_distance verification failed");
		$finish;
	end

	// squared distance test against one stored point
	function automatic bit is_close(pt_t p, pt_t q);
		longint            diff;
		longint unsigned   mag;
		longint unsigned   acc;
		pdd_pkg::coord_t   a [3];
		pdd_pkg::coord_t   b [3];
		a = '{p.x, p.y, p.z};
		b = '{q.x, q.y, q.z};
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			diff = longint'(a[k]) - longint'(b[k]);
			mag = (diff < 0) ? longint'(-diff) : diff;
			if (mag >= (64'd1 << pdd_pkg::FAR_BITS))
				return 1'b0;
			acc += mag * mag;
		end
		return acc < {{(64 - pdd_pkg::THRESH_BITS){1'b0}}, dist_limit};
	endfunction

	function automatic bit seen_before(pt_t p, int upto);
		for (int i = 0; i < upto && i < pdd_pkg::TABLE_DEPTH; i++)
			if (is_close(p, stored_pts[i]))
				return 1'b1;
		return 1'b0;
	endfunction

	// store a new point and queue its beat
	task automatic add_point(pt_t p, bit is_last);
		pdd_pkg::result_t r;
		r.point_x = p.x;
		r.point_y = p.y;
		r.point_z = p.z;
		r.last    = is_last;
		if (stored_cnt < pdd_pkg::TABLE_DEPTH) begin
			stored_pts[stored_cnt] = p;
			r.slot    = pdd_pkg::SLOT_BITS'(stored_cnt);
			r.dropped = 1'b0;
			stored_cnt++;
		end else begin
			r.slot    = '0;
			r.dropped = 1'b1;
		end
		pending_points = {pending_points, r};
	endtask

	// predicted effect of one accepted item
	task automatic track_item(pdd_pkg::item_t it);
		pt_t p1;
		pt_t p2;
		bit  new1;
		bit  new2;
		int  upto;
		if (it.kind == KIND_CLEAR) begin
			stored_cnt = 0;
			clears_taken++;
		end else begin
			p1 = '{it.first_x, it.first_y, it.first_z};
			p2 = '{it.second_x, it.second_y, it.second_z};
			upto = stored_cnt;
			new1 = !seen_before(p1, upto);
			new2 = !seen_before(p2, upto);
			if (new1)
				add_point(p1, !new2);
			if (new2)
				add_point(p2, 1'b1);
		end
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_points.size() == 0) begin
				$error("unexpected result beat: point (%0d, %0d, %0d) slot %0d",
					result.point_x, result.point_y, result.point_z, result.slot);
				mismatches++;
			end else begin
				chk_want = pending_points.pop_front();
				check_field("point_x", chk_want.point_x, result.point_x);
				check_field("point_y", chk_want.point_y, result.point_y);
				check_field("point_z", chk_want.point_z, result.point_z);
				check_field("slot", chk_want.slot, result.slot);
				check_field("dropped", chk_want.dropped, result.dropped);
				check_field("last", chk_want.last, result.last);
				beats_checked++;
				if (result.dropped)
					drops_seen++;
			end
		end
	end

	// one item through the start/busy handshake; start stays high afterwards
	task automatic send_item(pdd_pkg::item_t it);
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_taken++;
		track_item(it);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// wait until all beats are in and the block has finished any silent scan
	task automatic settle();
		start <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, then the port goes idle
	task automatic apb_write(logic [pdd_pkg::PADDR_BITS-1:0] addr,
		logic [pdd_pkg::PDATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_THRESH) begin
			dist_limit = data[pdd_pkg::THRESH_BITS-1:0];
			limits_used++;
		end
		@(posedge clk);
	endtask

	task automatic apb_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_THRESH;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		check_field("dist_sq_threshold", dist_limit, prdata[pdd_pkg::THRESH_BITS-1:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_limit(logic [pdd_pkg::PDATA_BITS-1:0] data);
		settle();
		apb_write(ADDR_THRESH, data);
		apb_readback();
	endtask

	function automatic pdd_pkg::item_t edge_of(pt_t a, pt_t b);
		pdd_pkg::item_t it;
		it.kind     = KIND_EDGE;
		it.first_x  = a.x;
		it.first_y  = a.y;
		it.first_z  = a.z;
		it.second_x = b.x;
		it.second_y = b.y;
		it.second_z = b.z;
		return it;
	endfunction

	function automatic pdd_pkg::item_t clear_of();
		pdd_pkg::item_t it;
		it = pdd_pkg::item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
		it.kind = KIND_CLEAR;
		return it;
	endfunction

	function automatic pt_t offset(pt_t p, int dx, int dy, int dz);
		return '{pdd_pkg::coord_t'(int'(p.x) + dx), pdd_pkg::coord_t'(int'(p.y) + dy),
			pdd_pkg::coord_t'(int'(p.z) + dz)};
	endfunction

	function automatic int wiggle(int j);
		return int'($urandom_range(0, 2 * j)) - j;
	endfunction

	// random endpoint: near a stored point, near the partner, clustered or anywhere
	function automatic pt_t pick_point(int jitter, bit has_partner, pt_t partner);
		int  r;
		pt_t p;
		r = $urandom_range(0, 99);
		if (r < 45 && stored_cnt > 0) begin
			p = stored_pts[$urandom_range(0, (stored_cnt > pdd_pkg::TABLE_DEPTH ?
				pdd_pkg::TABLE_DEPTH : stored_cnt) - 1)];
			return offset(p, wiggle(jitter), wiggle(jitter), wiggle(jitter));
		end
		if (r < 58 && has_partner)
			return offset(partner, wiggle(jitter), wiggle(jitter), wiggle(jitter));
		if (r < 75)
			return '{pdd_pkg::coord_t'(wiggle(2000)), pdd_pkg::coord_t'(wiggle(2000)),
				pdd_pkg::coord_t'(wiggle(2000))};
		return pt_t'({$urandom, $urandom, $urandom});
	endfunction

	// directed: field extremes, known points, boundary distances, clears
	task automatic test_edge_basics();
		pt_t hi, lo, org, alt1, alt2;
		hi   = '{pdd_pkg::coord_t'(24'h7FFFFF), pdd_pkg::coord_t'(24'h7FFFFF),
			pdd_pkg::coord_t'(24'h7FFFFF)};
		lo   = '{pdd_pkg::coord_t'(24'h800000), pdd_pkg::coord_t'(24'h800000),
			pdd_pkg::coord_t'(24'h800000)};
		org  = '{pdd_pkg::coord_t'(0), pdd_pkg::coord_t'(0), pdd_pkg::coord_t'(0)};
		alt1 = '{pdd_pkg::coord_t'(24'h555555), pdd_pkg::coord_t'(24'hAAAAAA),
			pdd_pkg::coord_t'(24'h555555)};
		alt2 = '{pdd_pkg::coord_t'(24'hAAAAAA), pdd_pkg::coord_t'(24'h555555),
			pdd_pkg::coord_t'(24'hAAAAAA)};
		// widest spread, then both endpoints already known either way round
		send_item(edge_of(hi, lo));
		send_item(edge_of(hi, lo));
		send_item(edge_of(lo, hi));
		// identical endpoints are both added
		send_item(edge_of(org, org));
		// squared distance 654 is a match, 656 is not
		send_item(edge_of(offset(org, 25, 5, 2), offset(org, 20, 16, 0)));
		send_item(edge_of(offset(org, -1, -1, -1), offset(org, -25, -5, -2)));
		// only the second endpoint is new
		send_item(edge_of(hi, offset(org, 0, 0, 5000)));
		send_item(clear_of());
		send_item(edge_of(org, offset(org, 25, 5, 2)));
		send_item(clear_of());
		send_item(clear_of());
		send_item(edge_of(alt1, alt2));
		send_item(edge_of(alt2, offset(alt1, 0, 0, 1)));
		send_item(edge_of(lo, org));
		pause(2);
		send_item(edge_of(hi, lo));
	endtask

	// directed: fill all slots, then overflow
	task automatic test_table_full();
		pt_t p [0:301];
		for (int k = 0; k < 302; k++)
			p[k] = '{pdd_pkg::coord_t'(k * 1024), pdd_pkg::coord_t'(-k * 512),
				pdd_pkg::coord_t'(k * 3)};
		set_limit(pdd_pkg::PDATA_BITS'(pdd_pkg::THRESH_RESET));
		send_item(clear_of());
		for (int k = 0; k < pdd_pkg::TABLE_DEPTH; k += 2)
			send_item(edge_of(p[k], p[k + 1]));
		send_item(edge_of(p[300], p[301]));
		// dropped points were never stored, so they come back dropped
		send_item(edge_of(p[300], p[0]));
		send_item(edge_of(p[5], p[6]));
		send_item(edge_of(p[0], p[301]));
		send_item(clear_of());
		send_item(edge_of(p[7], p[7]));
	endtask

	// directed: threshold register values and the unused address
	task automatic test_threshold_reg();
		pt_t org;
		org = '{pdd_pkg::coord_t'(100), pdd_pkg::coord_t'(-100), pdd_pkg::coord_t'(7)};
		settle();
		apb_readback();
		// equality with the limit does not count as a match
		set_limit(pdd_pkg::PDATA_BITS'(656));
		send_item(clear_of());
		send_item(edge_of(org, org));
		send_item(edge_of(offset(org, 20, 16, 0), offset(org, 25, 5, 2)));
		// zero limit: every endpoint is new
		set_limit('0);
		send_item(edge_of(org, org));
		// largest limit, upper data bits set: everything matches a stored point
		set_limit('1);
		send_item(edge_of('{pdd_pkg::coord_t'(24'h7FFFFF), pdd_pkg::coord_t'(24'h800000),
			pdd_pkg::coord_t'(0)},
			'{pdd_pkg::coord_t'(24'h800000), pdd_pkg::coord_t'(24'h7FFFFF),
			pdd_pkg::coord_t'(24'h7FFFFF)}));
		send_item(clear_of());
		send_item(edge_of(org, offset(org, 4000000, -4000000, 8000000)));
		// unused address leaves the threshold alone
		settle();
		apb_write(ADDR_UNUSED, 64'h5);
		apb_readback();
		send_item(edge_of(offset(org, 1, 1, 1), org));
	endtask

	// random phase under one threshold setting
	task automatic test_random(logic [pdd_pkg::PDATA_BITS-1:0] limit, int jitter,
		int clear_pct, int count, bit gaps);
		int  idle_pct;
		pt_t a;
		pt_t b;
		set_limit(limit);
		idle_pct = 0;
		for (int n = 0; n < count; n++) begin
			if (gaps && n % 40 == 0)
				idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(15, 60);
			if ($urandom_range(0, 99) < clear_pct) begin
				send_item(clear_of());
			end else begin
				a = pick_point(jitter, 1'b0, a);
				b = pick_point(jitter, 1'b1, a);
				send_item(edge_of(a, b));
			end
			if ($urandom_range(0, 99) < idle_pct)
				pause($urandom_range(1, 5));
		end
	endtask

	// main sequence
	initial begin
		arst_n  = 1'b0;
		start   <= 1'b0;
		item    <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		stored_cnt    = 0;
		dist_limit    = pdd_pkg::THRESH_RESET;
		mismatches    = 0;
		items_taken   = 0;
		clears_taken  = 0;
		beats_checked = 0;
		drops_seen    = 0;
		limits_used   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_basics();
		test_table_full();
		test_threshold_reg();
		test_random(pdd_pkg::PDATA_BITS'(pdd_pkg::THRESH_RESET), 24, 3, 220, 1'b1);
		test_random(64'd1 << 20, 900, 3, 200, 1'b1);
		test_random('0, 4, 3, 150, 1'b1);
		test_random(pdd_pkg::PDATA_BITS'(THRESH_MAX), 1000, 4, 100, 1'b1);
		test_random(64'd40000, 200, 1, 170, 1'b1);
		test_random(pdd_pkg::PDATA_BITS'(pdd_pkg::THRESH_RESET), 24, 3, 150, 1'b0);

		settle();
		$display("covered %0d items (%0d clears) under %0d threshold writes",
			items_taken, clears_taken, limits_used);
		$display("checked %0d new-point beats, %0d of them dropped on a full table",
			beats_checked, drops_seen);
		if (mismatches == 0)
			$display("point_dedup_by_distance verification clean");
		else
			$display("point_dedup_by_distance verification failed");
		$finish;
	end

endmodule
